// ----- sv/ctra_pkg.sv -----
package ctra_pkg;

  // window geometry: three history slots, the centre, three look-ahead slots
  localparam int unsigned WIN_DEPTH    = 7;
  localparam int unsigned CENTRE       = 3;
  localparam int unsigned PEND_DEPTH   = 4;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [4:0] {
    K_SURROUNDTAG      = 5'd0,
    K_NEXTTAG          = 5'd1,
    K_CURWD            = 5'd2,
    K_NEXTWD           = 5'd3,
    K_RBIGRAM          = 5'd4,
    K_WDNEXTTAG        = 5'd5,
    K_WDAND2AFT        = 5'd6,
    K_WDAND2TAGAFT     = 5'd7,
    K_NEXT2TAG         = 5'd8,
    K_NEXT2WD          = 5'd9,
    K_NEXTBIGRAM       = 5'd10,
    K_NEXT1OR2TAG      = 5'd11,
    K_NEXT1OR2WD       = 5'd12,
    K_NEXT1OR2OR3TAG   = 5'd13,
    K_NEXT1OR2OR3WD    = 5'd14,
    K_PREVTAG          = 5'd15,
    K_PREVWD           = 5'd16,
    K_LBIGRAM          = 5'd17,
    K_WDPREVTAG        = 5'd18,
    K_WDAND2BFR        = 5'd19,
    K_WDAND2TAGBFR     = 5'd20,
    K_PREV2TAG         = 5'd21,
    K_PREV2WD          = 5'd22,
    K_PREV1OR2TAG      = 5'd23,
    K_PREV1OR2WD       = 5'd24,
    K_PREV1OR2OR3TAG   = 5'd25,
    K_PREV1OR2OR3WD    = 5'd26,
    K_PREVBIGRAM       = 5'd27
  } rule_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RULE_KIND     = 3'd0,
    REG_OLD_TAG       = 3'd1,
    REG_NEW_TAG       = 3'd2,
    REG_FIRST_ARG     = 3'd3,
    REG_SECOND_ARG    = 3'd4,
    REG_KNOWN_LOCK    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic seen;
    logic known;
  } tok_flags_t;

  // window commands for one cycle
  typedef struct packed {
    logic insert;
    logic emit;
    logic restart;
  } win_cmd_t;

endpackage

// ----- sv/ctra_tok_if.sv -----
interface ctra_tok_if #(
  parameter int unsigned WORD_ID_BITS = 20,
  parameter int unsigned TAG_ID_BITS  = 8
);
  logic                    valid;
  logic                    ready;
  logic [WORD_ID_BITS-1:0] word_id;
  logic [TAG_ID_BITS-1:0]  tag_id;
  logic                    word_known;
  logic                    seen_with_new;
  logic                    last_token;

  modport source (
    output valid, word_id, tag_id, word_known, seen_with_new, last_token,
    input  ready
  );
  modport sink (
    input  valid, word_id, tag_id, word_known, seen_with_new, last_token,
    output ready
  );
endinterface

// ----- sv/ctra_res_if.sv -----
interface ctra_res_if #(
  parameter int unsigned TAG_ID_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [TAG_ID_BITS-1:0] tag_out;
  logic                   last_out;

  modport source (
    output valid, tag_out, last_out,
    input  ready
  );
  modport sink (
    input  valid, tag_out, last_out,
    output ready
  );
endinterface

// ----- sv/ctra_match.sv -----
module ctra_match #(
  parameter int unsigned WORD_ID_BITS = 20,
  parameter int unsigned TAG_ID_BITS  = 8
) (
  input  ctra_pkg::rule_kind_t     rule_kind,
  input  logic [TAG_ID_BITS-1:0]   old_tag,
  input  logic [TAG_ID_BITS-1:0]   new_tag,
  input  logic [WORD_ID_BITS-1:0]  first_arg,
  input  logic [WORD_ID_BITS-1:0]  second_arg,
  input  logic                     known_lock,
  input  logic [WORD_ID_BITS-1:0]  view_word [ctra_pkg::WIN_DEPTH],
  input  logic [TAG_ID_BITS-1:0]   view_tag [ctra_pkg::WIN_DEPTH],
  input  ctra_pkg::tok_flags_t     centre_flags,
  input  logic [1:0]               behind,
  input  logic [1:0]               ahead,
  output logic [TAG_ID_BITS-1:0]   centre_tag_out
);
  import ctra_pkg::*;

  localparam int unsigned CMP_BITS =
    (WORD_ID_BITS > TAG_ID_BITS) ? WORD_ID_BITS : TAG_ID_BITS;

  logic [CMP_BITS-1:0] x, y;
  logic                xt [WIN_DEPTH];
  logic                yt [WIN_DEPTH];
  logic                xw [WIN_DEPTH];
  logic                yw [WIN_DEPTH];
  logic                a1, a2, a3, p1, p2, p3;
  logic                fires, allowed;

  assign x = CMP_BITS'(first_arg);
  assign y = CMP_BITS'(second_arg);

  // tags compare against the whole argument value
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      xt[i] = (x == CMP_BITS'(view_tag[i]));
      yt[i] = (y == CMP_BITS'(view_tag[i]));
      xw[i] = (x == CMP_BITS'(view_word[i]));
      yw[i] = (y == CMP_BITS'(view_word[i]));
    end
  end

  assign a1 = (ahead  >= 2'd1);
  assign a2 = (ahead  >= 2'd2);
  assign a3 = (ahead  == 2'd3);
  assign p1 = (behind >= 2'd1);
  assign p2 = (behind >= 2'd2);
  assign p3 = (behind == 2'd3);

  // offset o sits at slot 3+o
  always_comb begin
    case (rule_kind)
      K_SURROUNDTAG:    fires = p1 && a1 && xt[2] && yt[4];
      K_NEXTTAG:        fires = a1 && xt[4];
      K_CURWD:          fires = xw[3];
      K_NEXTWD:         fires = a1 && xw[4];
      K_RBIGRAM:        fires = a1 && xw[3] && yw[4];
      K_WDNEXTTAG:      fires = a1 && xw[3] && yt[4];
      K_WDAND2AFT:      fires = a2 && xw[3] && yw[5];
      K_WDAND2TAGAFT:   fires = a2 && xw[3] && yt[5];
      K_NEXT2TAG:       fires = a2 && xt[5];
      K_NEXT2WD:        fires = a2 && xw[5];
      K_NEXTBIGRAM:     fires = a2 && xt[4] && yt[5];
      K_NEXT1OR2TAG:    fires = a1 && (xt[4] || (a2 && xt[5]));
      K_NEXT1OR2WD:     fires = a1 && (xw[4] || (a2 && xw[5]));
      K_NEXT1OR2OR3TAG: fires = a1 && (xt[4] || (a2 && xt[5]) || (a3 && xt[6]));
      K_NEXT1OR2OR3WD:  fires = a1 && (xw[4] || (a2 && xw[5]) || (a3 && xw[6]));
      K_PREVTAG:        fires = p1 && xt[2];
      K_PREVWD:         fires = p1 && xw[2];
      K_LBIGRAM:        fires = p1 && yw[3] && xw[2];
      K_WDPREVTAG:      fires = p1 && yw[3] && xt[2];
      K_WDAND2BFR:      fires = p2 && yw[3] && xw[1];
      K_WDAND2TAGBFR:   fires = p2 && yw[3] && xt[1];
      K_PREV2TAG:       fires = p2 && xt[1];
      K_PREV2WD:        fires = p2 && xw[1];
      K_PREV1OR2TAG:    fires = p1 && (xt[2] || (p2 && xt[1]));
      K_PREV1OR2WD:     fires = p1 && (xw[2] || (p2 && xw[1]));
      K_PREV1OR2OR3TAG: fires = p1 && (xt[2] || (p2 && xt[1]) || (p3 && xt[0]));
      K_PREV1OR2OR3WD:  fires = p1 && (xw[2] || (p2 && xw[1]) || (p3 && xw[0]));
      K_PREVBIGRAM:     fires = p2 && yt[2] && xt[1];
      default:          fires = 1'b0;
    endcase
  end

  assign allowed = !known_lock || !centre_flags.known || centre_flags.seen;

  always_comb begin
    centre_tag_out = view_tag[CENTRE];
    if ((view_tag[CENTRE] == old_tag) && allowed && fires) begin
      centre_tag_out = new_tag;
    end
  end

endmodule

// ----- sv/ctra_window.sv -----
module ctra_window #(
  parameter int unsigned WORD_ID_BITS = 20,
  parameter int unsigned TAG_ID_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctra_pkg::win_cmd_t       cmd,
  input  logic [WORD_ID_BITS-1:0]  in_word,
  input  logic [TAG_ID_BITS-1:0]   in_tag,
  input  ctra_pkg::tok_flags_t     in_flags,
  input  logic [TAG_ID_BITS-1:0]   centre_tag_new,
  output logic [WORD_ID_BITS-1:0]  view_word [ctra_pkg::WIN_DEPTH],
  output logic [TAG_ID_BITS-1:0]   view_tag [ctra_pkg::WIN_DEPTH],
  output ctra_pkg::tok_flags_t     centre_flags,
  output logic [1:0]               pending,
  output logic [1:0]               behind,
  output logic [1:0]               ahead
);
  import ctra_pkg::*;

  logic [WORD_ID_BITS-1:0] word_r [WIN_DEPTH];
  logic [WORD_ID_BITS-1:0] word_nxt [WIN_DEPTH];
  logic [TAG_ID_BITS-1:0]  tag_r [WIN_DEPTH];
  logic [TAG_ID_BITS-1:0]  tag_nxt [WIN_DEPTH];
  tok_flags_t              flag_r [PEND_DEPTH];
  tok_flags_t              flag_nxt [PEND_DEPTH];
  tok_flags_t              view_flag [PEND_DEPTH];
  logic [1:0]              va_r, va_nxt;
  logic [1:0]              ec_r, ec_nxt;
  logic [2:0]              va_eff;

  // new word lands in the first free pending slot
  always_comb begin
    for (int s = 0; s < WIN_DEPTH; s++) begin
      view_word[s] = word_r[s];
      view_tag[s]  = tag_r[s];
    end
    for (int s = 0; s < PEND_DEPTH; s++) begin
      view_flag[s] = flag_r[s];
      if (cmd.insert && (va_r == 2'(s))) begin
        view_word[CENTRE + s] = in_word;
        view_tag[CENTRE + s]  = in_tag;
        view_flag[s]          = in_flags;
      end
    end
  end

  assign centre_flags = view_flag[0];
  assign va_eff       = {1'b0, va_r} + 3'(cmd.insert);
  assign ahead        = 2'(va_eff - 3'd1);
  assign pending      = va_r;
  assign behind       = ec_r;

  always_comb begin
    for (int s = 0; s < WIN_DEPTH; s++) begin
      word_nxt[s] = view_word[s];
      tag_nxt[s]  = view_tag[s];
    end
    for (int s = 0; s < PEND_DEPTH; s++) begin
      flag_nxt[s] = view_flag[s];
    end
    if (cmd.emit) begin
      for (int s = 0; s < WIN_DEPTH - 1; s++) begin
        word_nxt[s] = view_word[s + 1];
        tag_nxt[s]  = view_tag[s + 1];
      end
      // decided centre tag moves into the newest history slot
      tag_nxt[CENTRE - 1] = centre_tag_new;
      for (int s = 0; s < PEND_DEPTH - 1; s++) begin
        flag_nxt[s] = view_flag[s + 1];
      end
    end
  end

  always_comb begin
    va_nxt = 2'(va_eff - 3'(cmd.emit));
    ec_nxt = ec_r;
    if (cmd.restart) begin
      va_nxt = 2'd0;
      ec_nxt = 2'd0;
    end else if (cmd.emit && (ec_r != 2'd3)) begin
      ec_nxt = ec_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 2'd0;
      ec_r <= 2'd0;
    end else begin
      va_r <= va_nxt;
      ec_r <= ec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    tag_r  <= tag_nxt;
    flag_r <= flag_nxt;
  end

endmodule

// ----- sv/contextual_tag_rule_applier.sv -----
// channel  dir  handshake            word
// in_tok   in   valid/ready          word_id, tag_id, word_known, seen_with_new, last_token
// out_res  out  valid/ready          tag_out, last_out
// cfg      in   cfg_we, no stall     cfg_addr selects register, cfg_wdata
//
// one token per cycle sustained while no flush runs and the result register has space;
// a causing token passes the input register, then the window step into the result register
// a token marked last emits all pending tokens, one per cycle while the result register
// has space, so it holds the input until the flush ends
// synchronous active-low reset clears control and rule registers, not the window data
// a stalled result register holds any window step that emits; an empty input register still fills
module contextual_tag_rule_applier #(
  parameter int unsigned WORD_ID_BITS = 20,
  parameter int unsigned TAG_ID_BITS  = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  ctra_tok_if.sink                               in_tok,
  ctra_res_if.source                             out_res,
  input  logic                                   cfg_we,
  input  logic [ctra_pkg::CFG_IDX_BITS-1:0]      cfg_addr,
  input  logic [((WORD_ID_BITS > TAG_ID_BITS) ? WORD_ID_BITS : TAG_ID_BITS)-1:0]
                                                 cfg_wdata
);
  import ctra_pkg::*;

  // rule registers
  rule_kind_t              rule_kind_r;
  logic [TAG_ID_BITS-1:0]  old_tag_r;
  logic [TAG_ID_BITS-1:0]  new_tag_r;
  logic [WORD_ID_BITS-1:0] first_arg_r;
  logic [WORD_ID_BITS-1:0] second_arg_r;
  logic                    known_lock_r;

  // input register
  logic                    inq_valid_r, inq_valid_nxt;
  logic [WORD_ID_BITS-1:0] inq_word_r;
  logic [TAG_ID_BITS-1:0]  inq_tag_r;
  tok_flags_t              inq_flags_r;
  logic                    inq_last_r;

  // result register
  logic                    res_valid_r, res_valid_nxt;
  logic [TAG_ID_BITS-1:0]  res_tag_r;
  logic                    res_last_r;

  // flush after a last token
  logic                    flush_r, flush_nxt;

  logic                    in_take;
  logic                    res_space;
  logic                    need_emit;
  logic                    step_in, step_flush;
  logic                    final_emit;
  win_cmd_t                win_cmd;

  logic [WORD_ID_BITS-1:0] view_word [WIN_DEPTH];
  logic [TAG_ID_BITS-1:0]  view_tag [WIN_DEPTH];
  tok_flags_t              centre_flags;
  logic [1:0]              pending, behind, ahead;
  logic [TAG_ID_BITS-1:0]  centre_tag_new;

  // configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_kind_r     <= K_SURROUNDTAG;
      old_tag_r       <= '0;
      new_tag_r       <= '0;
      first_arg_r     <= '0;
      second_arg_r    <= '0;
      known_lock_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RULE_KIND:     rule_kind_r     <= rule_kind_t'(cfg_wdata[4:0]);
        REG_OLD_TAG:       old_tag_r       <= cfg_wdata[TAG_ID_BITS-1:0];
        REG_NEW_TAG:       new_tag_r       <= cfg_wdata[TAG_ID_BITS-1:0];
        REG_FIRST_ARG:     first_arg_r     <= cfg_wdata[WORD_ID_BITS-1:0];
        REG_SECOND_ARG:    second_arg_r    <= cfg_wdata[WORD_ID_BITS-1:0];
        REG_KNOWN_LOCK:    known_lock_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // step control
  // a token emits when it fills the fourth pending slot or closes the corpus
  assign res_space  = !res_valid_r || out_res.ready;
  assign need_emit  = inq_last_r || (pending == 2'd3);
  assign step_in    = inq_valid_r && !flush_r && (!need_emit || res_space);
  assign step_flush = flush_r && res_space;

  assign win_cmd.insert  = step_in;
  assign win_cmd.emit    = (step_in && need_emit) || step_flush;
  // the oldest pending token with nothing ahead is the corpus's final result
  assign final_emit      = win_cmd.emit && (flush_r || inq_last_r) && (ahead == 2'd0);
  assign win_cmd.restart = final_emit;

  always_comb begin
    flush_nxt = flush_r;
    if (final_emit) begin
      flush_nxt = 1'b0;
    end else if (step_in && inq_last_r) begin
      flush_nxt = 1'b1;
    end
  end

  // input register: refills in the cycle it is drained
  assign in_tok.ready = !inq_valid_r || step_in;
  assign in_take      = in_tok.valid && in_tok.ready;

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_take) begin
      inq_valid_nxt = 1'b1;
    end else if (step_in) begin
      inq_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (win_cmd.emit) begin
      res_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      flush_r     <= 1'b0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      res_valid_r <= res_valid_nxt;
      flush_r     <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_word_r        <= in_tok.word_id;
      inq_tag_r         <= in_tok.tag_id;
      inq_flags_r.known <= in_tok.word_known;
      inq_flags_r.seen  <= in_tok.seen_with_new;
      inq_last_r        <= in_tok.last_token;
    end
    if (win_cmd.emit) begin
      res_tag_r  <= centre_tag_new;
      res_last_r <= final_emit;
    end
  end

  assign out_res.valid    = res_valid_r;
  assign out_res.tag_out  = res_tag_r;
  assign out_res.last_out = res_last_r;

  // seven-slot token window
  ctra_window #(
    .WORD_ID_BITS (WORD_ID_BITS),
    .TAG_ID_BITS  (TAG_ID_BITS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (win_cmd),
    .in_word        (inq_word_r),
    .in_tag         (inq_tag_r),
    .in_flags       (inq_flags_r),
    .centre_tag_new (centre_tag_new),
    .view_word      (view_word),
    .view_tag       (view_tag),
    .centre_flags   (centre_flags),
    .pending        (pending),
    .behind         (behind),
    .ahead          (ahead)
  );

  // template compare and retag decision for the centre token
  ctra_match #(
    .WORD_ID_BITS (WORD_ID_BITS),
    .TAG_ID_BITS  (TAG_ID_BITS)
  ) u_match (
    .rule_kind      (rule_kind_r),
    .old_tag        (old_tag_r),
    .new_tag        (new_tag_r),
    .first_arg      (first_arg_r),
    .second_arg     (second_arg_r),
    .known_lock     (known_lock_r),
    .view_word      (view_word),
    .view_tag       (view_tag),
    .centre_flags   (centre_flags),
    .behind         (behind),
    .ahead          (ahead),
    .centre_tag_out (centre_tag_new)
  );

`ifndef SYNTHESIS
  // no new token enters the window while a corpus is being flushed
  a_no_insert_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !win_cmd.insert)
    else $error("token inserted during flush");

  // a held result is never overwritten
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_res.ready) |-> !win_cmd.emit)
    else $error("result overwritten while stalled");

  // the final result leaves an empty window and no history
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    final_emit |=> (pending == 2'd0) && (behind == 2'd0) && !flush_r)
    else $error("window not cleared after final result");

  // a plain insert grows the pending count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (win_cmd.insert && !win_cmd.emit) |=> (pending == $past(pending) + 2'd1))
    else $error("pending count wrong after insert");
`endif

endmodule
